FILE: rtl/core/sdim_pkg.sv
package sdim_pkg;

	// Table geometry. TABLE_ENTRIES must be a power of two between 16 and 65536.
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;

	// Field widths fixed by the interface.
	localparam int KEY_W    = 32;
	localparam int NIDX_W   = 10;
	localparam int STATUS_W = 3;

	localparam logic [KEY_W-1:0] MASK_RESET = 32'hFFFF_FF00;
	localparam logic [KEY_W-1:0] HASH_MULT  = 32'd2654435761;
	localparam int               HASH_SHIFT = 16;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 3'd0,
		ST_NEW       = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_FULL      = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	// One table slot as it is held in memory.
	typedef struct packed {
		logic              valid;
		logic [NIDX_W-1:0] index;
		logic [KEY_W-1:0]  key;
	} slot_t;

endpackage

FILE: rtl/core/subnet_dense_index_map_top.sv
// Subnet dense index map. Each request transfer carries an IPv4 client address; the address
// is ANDed with the subnet mask (255.255.255.0 after reset; the user is to rewrite it through
// the cfg port only while the block is idle, which the block itself does not enforce) and the
// masked key is looked up in a 1024-slot open-addressed hash table with linear probing, held
// in one single-port synchronous RAM. A key already present returns its stored index with
// status found; a new key receives the next dense index in order of first appearance with
// status new. Malformed requests, new keys arriving at a full table, and clear requests
// return index zero with their own status codes. Exactly one result transfer follows every
// request transfer, in order. A lookup hashes the key, then reads its home slot from the
// table RAM and compares it, repeating the read and compare for every further slot the probe
// visits; a malformed request goes straight to emit. A clear request sweeps the RAM one slot
// per cycle; the same sweep runs after reset, during which in_stall is high while
// configuration writes are still taken. A finished result waits in the output register,
// and the next request is accepted while it is held there.
module subnet_dense_index_map_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [sdim_pkg::KEY_W-1:0]     client_addr,
	input  logic                           malformed,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sdim_pkg::NIDX_W-1:0]    net_index,
	output logic [sdim_pkg::STATUS_W-1:0]  status,
	// Subnet mask register write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sdim_pkg::KEY_W-1:0]     cfg_data
);
	import sdim_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HASH  = 6'b000010,
		S_READ  = 6'b000100,
		S_CHECK = 6'b001000,
		S_EMIT  = 6'b010000,
		S_CLEAR = 6'b100000
	} state_t;

	state_t              state_q;
	logic [KEY_W-1:0]    mask_q;
	logic [KEY_W-1:0]    key_q;
	logic [IDX_W-1:0]    pos_q;
	logic [CNT_W-1:0]    probe_q;
	logic [CNT_W-1:0]    next_index_q;
	logic                clr_emit_q;
	logic [NIDX_W-1:0]   res_index_q;
	status_t             res_status_q;
	logic                out_valid_q;
	logic [NIDX_W-1:0]   net_index_q;
	status_t             status_q;

	// Table RAM: key, dense index and valid flag of every slot.
	slot_t               slot_mem [TABLE_ENTRIES];
	slot_t               rd_q;
	logic                mem_we;
	logic                mem_re;
	slot_t               mem_wdata;

	logic [KEY_W-1:0]    prod;
	logic [31:0]         next_wide;
	logic [NIDX_W-1:0]   next_narrow;
	logic                hit;
	logic                table_full;
	logic                last_probe;
	logic                out_free;
	logic                accept;

	// The hash only places entries: the low word of key times the golden-ratio constant,
	// with the slot number taken from bits above HASH_SHIFT.
	assign prod        = KEY_W'(key_q * HASH_MULT);
	assign next_wide   = 32'(next_index_q);
	assign next_narrow = next_wide[NIDX_W-1:0];
	assign hit         = rd_q.valid && (rd_q.key == key_q);
	assign table_full  = next_index_q == CNT_W'(TABLE_ENTRIES);
	assign last_probe  = probe_q == CNT_W'(TABLE_ENTRIES - 1);
	assign out_free    = !out_valid_q || !out_stall;

	// Requests are taken only in idle; a held result does not block the request side.
	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign net_index = net_index_q;
	assign status    = status_q;

	// A free slot is claimed in the check cycle; the sweep writes empty slots. Reads and
	// writes fall in different states, so no forwarding is needed between items.
	assign mem_re    = state_q == S_READ;
	assign mem_we    = (state_q == S_CLEAR) ||
	                   ((state_q == S_CHECK) && !rd_q.valid && !table_full);
	assign mem_wdata = (state_q == S_CLEAR) ? slot_t'('0) : slot_t'({1'b1, next_narrow, key_q});

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[pos_q] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= slot_mem[pos_q];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			mask_q       <= MASK_RESET;
			pos_q        <= '0;
			probe_q      <= '0;
			next_index_q <= '0;
			clr_emit_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			// The output register loads in the emit state and empties on a transfer out.
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_CLEAR) begin
							pos_q      <= '0;
							clr_emit_q <= 1'b1;
							state_q    <= S_CLEAR;
						end else if (malformed) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					pos_q   <= prod[HASH_SHIFT +: IDX_W];
					probe_q <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!rd_q.valid) begin
						if (!table_full) begin
							next_index_q <= next_index_q + CNT_W'(1);
						end
						state_q <= S_EMIT;
					end else if (hit || last_probe) begin
						state_q <= S_EMIT;
					end else begin
						// Linear probing; the slot number wraps at the table size.
						pos_q   <= pos_q + IDX_W'(1);
						probe_q <= probe_q + CNT_W'(1);
						state_q <= S_READ;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					pos_q <= pos_q + IDX_W'(1);
					if (pos_q == '1) begin
						next_index_q <= '0;
						clr_emit_q   <= 1'b0;
						state_q      <= clr_emit_q ? S_EMIT : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: masked key, pending result and output register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q <= client_addr & mask_q;
					if (op == OP_CLEAR) begin
						res_index_q  <= '0;
						res_status_q <= ST_CLEARED;
					end else if (malformed) begin
						res_index_q  <= '0;
						res_status_q <= ST_MALFORMED;
					end
				end
			end
			S_CHECK: begin
				if (!rd_q.valid) begin
					if (table_full) begin
						res_index_q  <= '0;
						res_status_q <= ST_FULL;
					end else begin
						res_index_q  <= next_narrow;
						res_status_q <= ST_NEW;
					end
				end else if (hit) begin
					res_index_q  <= rd_q.index;
					res_status_q <= ST_FOUND;
				end else if (last_probe) begin
					res_index_q  <= '0;
					res_status_q <= ST_FULL;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					net_index_q <= res_index_q;
					status_q    <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/sdim_checker.sv
module sdim_assertions (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sdim_pkg::NIDX_W-1:0]   net_index,
	input logic [sdim_pkg::STATUS_W-1:0] status
);
	import sdim_pkg::*;

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(net_index) && $stable(status))
		else $error("stalled result changed");

	// Only found and new results carry an index.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(status == ST_FOUND || status == ST_NEW) |-> net_index == '0)
		else $error("error status with nonzero index");

	// One request at a time: after a transfer in, the request side is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while previous one in flight");

endmodule

bind subnet_dense_index_map_top sdim_assertions u_sdim_assertions (.*);
